### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the trie order statistic block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define XTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define XTS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/xts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xts_pkg
// sizes, codes and node entry layout for the trie order statistic block
// ---------------------------------------------------------------------------
package xts_pkg;

    localparam int KEY_BITS      = 30;
    localparam int NODE_CAPACITY = 65536;
    localparam int COUNT_BITS    = 24;

    localparam int NODE_BITS  = $clog2(NODE_CAPACITY);
    localparam int LVL_BITS   = $clog2(KEY_BITS);
    localparam int ENTRY_BITS = 2 * NODE_BITS + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // action codes
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_ERASE  = 3'd1;
    localparam logic [2:0] ACT_KTH    = 3'd2;
    localparam logic [2:0] ACT_XOR    = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // one trie node: two child links and a pass-through count
    typedef struct packed {
        logic [NODE_BITS-1:0]  c0;
        logic [NODE_BITS-1:0]  c1;
        logic [COUNT_BITS-1:0] cnt;
    } entry_t;

    function automatic logic [NODE_BITS-1:0] child_of(input entry_t e, input logic b);
        return b ? e.c1 : e.c0;
    endfunction

    function automatic entry_t with_child(input entry_t e, input logic b,
                                          input logic [NODE_BITS-1:0] c);
        entry_t r;
        r = e;
        if (b)
        begin
            r.c1 = c;
        end
        else
        begin
            r.c0 = c;
        end
        return r;
    endfunction

endpackage

### rtl/core/xts_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xts_ram
// generic simple dual port ram, one write port, registered read port
// ---------------------------------------------------------------------------
module xts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/xor_trie_order_statistic.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// xor_trie_order_statistic
// counted binary trie multiset of keys with a global xor mask and kth query
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Exactly one result
// follows each word: done is high for one cycle with status and answer, and
// the receiver must take it then, as it cannot stall the block. Mask updates,
// clear, unused action codes and rejected ranks answer in the cycle after the
// word. Insert and erase walk the trie in a check pass and, if that passes,
// again in an update pass; a kth query also weighs the preferred child where
// it exists. The walks are paced by the single node memory: every level needs
// a read with a registered result, and updates write back through the same
// memory before the next read. The root node lives in flip-flops, so clear
// takes effect at once and needs no sweep of the memory; the other nodes are
// always written when they are allocated, before they are ever read.
// ---------------------------------------------------------------------------
module xor_trie_order_statistic (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [29:0] value,
    input  logic [23:0] rank,
    output logic        done,
    output logic [1:0]  status,
    output logic [29:0] answer
);

    import xts_pkg::*;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,   // read the current node
        S_EVAL  = 6'b000100,   // act on the current node entry
        S_CHECK = 6'b001000,   // insert capacity check
        S_CHAIN = 6'b010000,   // allocate fresh nodes below the branch point
        S_KCNT  = 6'b100000    // kth query: weigh the preferred child
    } state_t;

    // which walk is under way
    typedef enum logic [2:0] {
        P_INS_CHK,
        P_INS_UPD,
        P_ERS_CHK,
        P_ERS_UPD,
        P_KTH
    } pass_t;

    localparam logic [LVL_BITS-1:0] LVL_TOP    = LVL_BITS'(KEY_BITS - 1);
    localparam logic [NODE_BITS:0]  NF_LIMIT   = (NODE_BITS + 1)'(NODE_CAPACITY);
    localparam logic [NODE_BITS+1:0] CAP_WIDE  = (NODE_BITS + 2)'(NODE_CAPACITY);

    state_t                 state_reg,    state_next;
    pass_t                  pass_reg,     pass_next;
    logic [NODE_BITS-1:0]   cur_reg,      cur_next;
    logic [NODE_BITS-1:0]   alt_reg,      alt_next;
    logic [LVL_BITS-1:0]    lvl_reg,      lvl_next;
    logic                   leaf_reg,     leaf_next;
    logic [KEY_BITS-1:0]    key_reg,      key_next;
    logic [COUNT_BITS-1:0]  k_reg,        k_next;
    logic [KEY_BITS-1:0]    ans_reg,      ans_next;
    logic [LVL_BITS:0]      needed_reg,   needed_next;
    logic [NODE_BITS:0]     nf_reg,       nf_next;
    logic [KEY_BITS-1:0]    mask_reg,     mask_next;
    logic [NODE_BITS-1:0]   root_c0_reg,  root_c0_next;
    logic [NODE_BITS-1:0]   root_c1_reg,  root_c1_next;
    logic [COUNT_BITS-1:0]  root_cnt_reg, root_cnt_next;
    logic                   done_reg,     done_next;
    logic [1:0]             status_reg,   status_next;
    logic [29:0]            answer_reg,   answer_next;

    // node memory port
    logic                   wr_en;
    logic [NODE_BITS-1:0]   wr_addr;
    entry_t                 wr_ent;
    logic                   rd_en;
    logic [NODE_BITS-1:0]   rd_addr;
    logic [ENTRY_BITS-1:0]  rd_data;

    // working signals
    entry_t                 root_ent;
    entry_t                 mem_ent;
    entry_t                 ent;
    entry_t                 upd;
    entry_t                 fresh;
    logic                   kbit;
    logic                   pref;
    logic [NODE_BITS-1:0]   c_sel;
    logic [NODE_BITS-1:0]   pc;
    logic [NODE_BITS-1:0]   oc;
    logic [LVL_BITS-1:0]    lvl_dn;
    logic [NODE_BITS+1:0]   need_sum;
    logic [NODE_BITS-1:0]   nf_idx;
    logic [NODE_BITS-1:0]   nf_idx_inc;

    xts_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (NODE_CAPACITY)
    ) u_nodes (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_ent),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // node zero is the root, held in flip-flops; every other node comes from memory
    assign root_ent = '{c0: root_c0_reg, c1: root_c1_reg, cnt: root_cnt_reg};
    assign mem_ent  = entry_t'(rd_data);
    assign ent      = (cur_reg == '0) ? root_ent : mem_ent;

    assign lvl_dn     = lvl_reg - 1'b1;
    assign kbit       = key_reg[lvl_reg];
    assign pref       = mask_reg[lvl_reg];
    assign c_sel      = child_of(ent, kbit);
    assign pc         = child_of(ent, pref);
    assign oc         = child_of(ent, ~pref);
    assign need_sum   = {1'b0, nf_reg} + (NODE_BITS + 2)'(needed_reg);
    assign nf_idx     = nf_reg[NODE_BITS-1:0];
    assign nf_idx_inc = nf_idx + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        cur_next      = cur_reg;
        alt_next      = alt_reg;
        lvl_next      = lvl_reg;
        leaf_next     = leaf_reg;
        key_next      = key_reg;
        k_next        = k_reg;
        ans_next      = ans_reg;
        needed_next   = needed_reg;
        nf_next       = nf_reg;
        mask_next     = mask_reg;
        root_c0_next  = root_c0_reg;
        root_c1_next  = root_c1_reg;
        root_cnt_next = root_cnt_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        answer_next   = answer_reg;
        wr_en         = 1'b0;
        wr_addr       = cur_reg;
        wr_ent        = ent;
        rd_en         = 1'b0;
        rd_addr       = cur_reg;
        upd           = ent;
        fresh         = '{c0: '0, c1: '0, cnt: COUNT_BITS'(1)};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cur_next  = '0;
                    lvl_next  = LVL_TOP;
                    leaf_next = 1'b0;
                    key_next  = value[KEY_BITS-1:0] ^ mask_reg;
                    case (action)
                        ACT_INSERT:
                        begin
                            pass_next  = P_INS_CHK;
                            state_next = S_FETCH;
                        end
                        ACT_ERASE:
                        begin
                            pass_next  = P_ERS_CHK;
                            state_next = S_FETCH;
                        end
                        ACT_KTH:
                        begin
                            if (rank == '0 || rank > root_cnt_reg)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                                answer_next = '0;
                            end
                            else
                            begin
                                pass_next  = P_KTH;
                                k_next     = rank;
                                ans_next   = '0;
                                state_next = S_FETCH;
                            end
                        end
                        ACT_XOR:
                        begin
                            mask_next   = mask_reg ^ value[KEY_BITS-1:0];
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            answer_next = '0;
                        end
                        ACT_CLEAR:
                        begin
                            root_c0_next  = '0;
                            root_c1_next  = '0;
                            root_cnt_next = '0;
                            nf_next       = (NODE_BITS + 1)'(1);
                            mask_next     = '0;
                            done_next     = 1'b1;
                            status_next   = ST_OK;
                            answer_next   = '0;
                        end
                        default:
                        begin
                            // unused codes answer ok and change nothing
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            answer_next = '0;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                rd_en      = (cur_reg != '0);
                rd_addr    = cur_reg;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                case (pass_reg)
                    P_INS_CHK:
                    begin
                        // find where the key leaves the existing trie
                        if (c_sel == '0)
                        begin
                            needed_next = {1'b0, lvl_reg} + 1'b1;
                            state_next  = S_CHECK;
                        end
                        else if (lvl_reg == '0)
                        begin
                            needed_next = '0;
                            state_next  = S_CHECK;
                        end
                        else
                        begin
                            cur_next   = c_sel;
                            lvl_next   = lvl_dn;
                            state_next = S_FETCH;
                        end
                    end

                    P_INS_UPD:
                    begin
                        upd.cnt = ent.cnt + 1'b1;
                        if (leaf_reg)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            answer_next = '0;
                            state_next  = S_IDLE;
                        end
                        else if (c_sel == '0)
                        begin
                            // branch point: hang the next free node here
                            upd        = with_child(upd, kbit, nf_idx);
                            state_next = S_CHAIN;
                        end
                        else
                        begin
                            cur_next   = c_sel;
                            state_next = S_FETCH;
                            if (lvl_reg == '0)
                            begin
                                leaf_next = 1'b1;
                            end
                            else
                            begin
                                lvl_next = lvl_dn;
                            end
                        end
                        if (cur_reg == '0)
                        begin
                            root_c0_next  = upd.c0;
                            root_c1_next  = upd.c1;
                            root_cnt_next = upd.cnt;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = cur_reg;
                            wr_ent  = upd;
                        end
                    end

                    P_ERS_CHK:
                    begin
                        if (ent.cnt == '0 || (!leaf_reg && c_sel == '0))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOT_FOUND;
                            answer_next = '0;
                            state_next  = S_IDLE;
                        end
                        else if (leaf_reg)
                        begin
                            // key present: walk again and take one copy off
                            pass_next  = P_ERS_UPD;
                            cur_next   = '0;
                            lvl_next   = LVL_TOP;
                            leaf_next  = 1'b0;
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            cur_next   = c_sel;
                            state_next = S_FETCH;
                            if (lvl_reg == '0)
                            begin
                                leaf_next = 1'b1;
                            end
                            else
                            begin
                                lvl_next = lvl_dn;
                            end
                        end
                    end

                    P_ERS_UPD:
                    begin
                        upd.cnt = ent.cnt - 1'b1;
                        if (cur_reg == '0)
                        begin
                            root_cnt_next = upd.cnt;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = cur_reg;
                            wr_ent  = upd;
                        end
                        if (leaf_reg)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            answer_next = '0;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            cur_next   = c_sel;
                            state_next = S_FETCH;
                            if (lvl_reg == '0)
                            begin
                                leaf_next = 1'b1;
                            end
                            else
                            begin
                                lvl_next = lvl_dn;
                            end
                        end
                    end

                    P_KTH:
                    begin
                        if (pc != '0)
                        begin
                            // fetch the preferred child to see its weight
                            cur_next   = pc;
                            alt_next   = oc;
                            rd_en      = 1'b1;
                            rd_addr    = pc;
                            state_next = S_KCNT;
                        end
                        else
                        begin
                            // empty preferred side: the answer bit is set
                            ans_next[lvl_reg] = 1'b1;
                            cur_next          = oc;
                            if (lvl_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_OK;
                                answer_next = 30'(ans_next);
                                state_next  = S_IDLE;
                            end
                            else
                            begin
                                lvl_next   = lvl_dn;
                                state_next = S_FETCH;
                            end
                        end
                    end

                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_CHECK:
            begin
                if (root_cnt_reg == COUNT_MAX || need_sum > CAP_WIDE)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FULL;
                    answer_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    pass_next  = P_INS_UPD;
                    cur_next   = '0;
                    lvl_next   = LVL_TOP;
                    leaf_next  = 1'b0;
                    state_next = S_FETCH;
                end
            end

            S_CHAIN:
            begin
                // each new node but the last points straight at the one allocated after it
                if (lvl_reg != '0)
                begin
                    fresh = with_child(fresh, key_reg[lvl_dn], nf_idx_inc);
                end
                wr_en   = 1'b1;
                wr_addr = nf_idx;
                wr_ent  = fresh;
                nf_next = nf_reg + 1'b1;
                if (lvl_reg == '0)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    answer_next = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    lvl_next = lvl_dn;
                end
            end

            S_KCNT:
            begin
                if (mem_ent.cnt >= k_reg)
                begin
                    // stay on the preferred child, its entry is already read
                    if (lvl_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        answer_next = 30'(ans_reg);
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        lvl_next   = lvl_dn;
                        state_next = S_EVAL;
                    end
                end
                else
                begin
                    k_next            = k_reg - mem_ent.cnt;
                    ans_next[lvl_reg] = 1'b1;
                    cur_next          = alt_reg;
                    if (lvl_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        answer_next = 30'(ans_next);
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        lvl_next   = lvl_dn;
                        state_next = S_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            nf_reg       <= (NODE_BITS + 1)'(1);
            mask_reg     <= '0;
            root_c0_reg  <= '0;
            root_c1_reg  <= '0;
            root_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            nf_reg       <= nf_next;
            mask_reg     <= mask_next;
            root_c0_reg  <= root_c0_next;
            root_c1_reg  <= root_c1_next;
            root_cnt_reg <= root_cnt_next;
            done_reg     <= done_next;
        end
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        pass_reg   <= pass_next;
        cur_reg    <= cur_next;
        alt_reg    <= alt_next;
        lvl_reg    <= lvl_next;
        leaf_reg   <= leaf_next;
        key_reg    <= key_next;
        k_reg      <= k_next;
        ans_reg    <= ans_next;
        needed_reg <= needed_next;
        status_reg <= status_next;
        answer_reg <= answer_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign answer = answer_reg;

    // a result only ever appears once the sequencer is back at rest
    `XTS_ASSERT(a_done_idle, done |-> !busy, "result word while the walk is running")
    // every accepted word either starts a walk or answers at once
    `XTS_ASSERT(a_accept_reacts, (start && !busy) |=> (busy || done), "accepted word ignored")
    // only a successful query carries a non-zero answer
    `XTS_ASSERT(a_answer_ok, (done && answer != '0) |-> (status == ST_OK), "answer with error")
    // the allocator never runs past the node pool
    `XTS_NEVER(a_pool_bound, nf_reg > NF_LIMIT, "node pool overrun")

endmodule
